### rtl/core/imu_aqu_pkg.sv
package imu_aqu_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] RegTwoKp        = 2'd0;
  localparam logic [1:0] RegTwoKi        = 2'd1;
  localparam logic [1:0] RegSamplePeriod = 2'd2;

  localparam logic [31:0] TwoKpReset  = 32'd16777216;
  localparam logic [31:0] TwoKiReset  = 32'd0;
  localparam logic [31:0] PeriodReset = 32'd4294967;

  localparam logic signed [31:0] QuatOne  = 32'sh4000_0000;
  localparam logic signed [39:0] HalfQ30  = 40'sh00_2000_0000;
  localparam logic signed [33:0] ThreeQ30 = 34'sh0_C000_0000;

  localparam logic signed [67:0] Max32 = 68'sd2147483647;
  localparam logic signed [67:0] Min32 = -68'sd2147483648;

  // reciprocal square root seeds, indexed by the top mantissa nibble minus four
  function automatic logic [14:0] seed_lut(input logic [3:0] idx);
    logic [14:0] r;
    case (idx)
      4'd0:    r = 15'd30894;
      4'd1:    r = 15'd27945;
      4'd2:    r = 15'd25705;
      4'd3:    r = 15'd23930;
      4'd4:    r = 15'd22479;
      4'd5:    r = 15'd21263;
      4'd6:    r = 15'd20225;
      4'd7:    r = 15'd19325;
      4'd8:    r = 15'd18536;
      4'd9:    r = 15'd17837;
      4'd10:   r = 15'd17211;
      4'd11:   r = 15'd16646;
      default: r = 15'd16646;
    endcase
    return r;
  endfunction

  // arithmetic right shift by s (s >= 1), round half up
  function automatic logic signed [67:0] rsh_rnd(input logic signed [67:0] p,
                                                 input logic [5:0] s);
    logic signed [67:0] r;
    logic [5:0] b;
    b = s - 6'd1;
    r = p >>> s;
    return r + $signed({67'd0, p[b]});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > Max32) begin
      r = 32'sh7fff_ffff;
    end else if (v < Min32) begin
      r = -32'sh7fff_ffff - 32'sd1;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

### rtl/core/imu_attitude_quaternion_update.sv
// The result of an accepted input beat waits in the done state while the previous result
// is still held. Throughput: one sample at a time; every product goes through one shared
// 34x34 multiplier, and each normalisation runs a shift loop and then RSQRT_ITERATIONS
// Newton iterations of three products each on that multiplier (four iterations here).
// Reset: attitude (1, 0, 0, 0), integrals zero, gains and period at their defaults.
module imu_attitude_quaternion_update
  import imu_aqu_pkg::*;
#(
  parameter int RSQRT_ITERATIONS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  rate_x_i,
  input  logic signed [31:0]  rate_y_i,
  input  logic signed [31:0]  rate_z_i,
  input  logic signed [31:0]  accel_x_i,
  input  logic signed [31:0]  accel_y_i,
  input  logic signed [31:0]  accel_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  quat_w_o,
  output logic signed [31:0]  quat_x_o,
  output logic signed [31:0]  quat_y_o,
  output logic signed [31:0]  quat_z_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int ItW = (RSQRT_ITERATIONS > 1) ? $clog2(RSQRT_ITERATIONS) : 1;
  localparam logic [ItW-1:0] ItLast = ItW'(RSQRT_ITERATIONS - 1);

  localparam logic [5:0] StepH    = 6'd21;
  localparam logic [5:0] StepLast = 6'd35;

  typedef enum logic [3:0] {
    S_IDLE, S_NMAG, S_NSQ, S_NCHK, S_NSHF, S_NSEED, S_NNEWT, S_NOUT, S_NEND,
    S_CALC, S_DONE
  } state_e;

  typedef enum logic [2:0] {C_NONE, C_LIN, C_FB0, C_FB1, C_FB2, C_H} cls_e;

  // configuration
  logic [31:0] two_kp_q, two_ki_q, period_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_kp_q <= TwoKpReset;
      two_ki_q <= TwoKiReset;
      period_q <= PeriodReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegTwoKp:        two_kp_q <= pwdata;
        RegTwoKi:        two_ki_q <= pwdata;
        RegSamplePeriod: period_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegTwoKp:        prdata = two_kp_q;
      RegTwoKi:        prdata = two_ki_q;
      RegSamplePeriod: prdata = period_q;
      default:         prdata = '0;
    endcase
  end

  // state and working registers
  state_e              state_q;
  logic                phase_q;
  logic [5:0]          step_q;
  logic [1:0]          el_q;
  logic [1:0]          sub_q;
  logic [ItW-1:0]      it_q;
  logic                norm_qn_q, nz_q, out_valid_q;

  logic signed [31:0]  att_q [4];
  logic signed [31:0]  integ_q [3];
  logic signed [33:0]  g_q [3];
  logic signed [31:0]  an_q [3];
  logic signed [31:0]  hv_q [3];
  logic signed [31:0]  he_q [3];
  logic signed [31:0]  h_q [3];
  logic signed [31:0]  nout_q [4];
  logic signed [35:0]  nv_q [4];
  logic [30:0]         mag_q [4];
  logic [3:0]          neg_q;
  logic [63:0]         s_q, m_q;
  logic [4:0]          e_q;
  logic [31:0]         y_q;
  logic [32:0]         y2_q, t_q;
  logic [30:0]         m31_q;
  logic signed [39:0]  acc_q;
  logic signed [67:0]  prod_q;

  // shared multiplier, product registered every cycle
  logic signed [33:0]  mul_a, mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // operand selection and step decode
  cls_e                cls;
  logic [1:0]          ax;
  logic                lin_neg, lin_first;
  logic signed [39:0]  lin_base;
  logic [5:0]          sh;
  logic signed [33:0]  mag34, diff;

  assign mag34 = $signed({3'd0, mag_q[el_q]});
  assign diff  = ThreeQ30 - $signed({1'b0, t_q});

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    cls       = C_NONE;
    ax        = 2'd0;
    lin_neg   = 1'b0;
    lin_first = 1'b0;
    lin_base  = '0;
    sh        = 6'd30;
    case (state_q)
      S_NSQ: begin
        mul_a = mag34;
        mul_b = mag34;
      end
      S_NNEWT: begin
        case (sub_q)
          2'd0: begin
            mul_a = $signed({2'd0, y_q});
            mul_b = $signed({2'd0, y_q});
          end
          2'd1: begin
            mul_a = $signed({3'd0, m31_q});
            mul_b = $signed({1'b0, y2_q});
          end
          default: begin
            mul_a = $signed({2'd0, y_q});
            mul_b = diff;
          end
        endcase
      end
      S_NOUT: begin
        mul_a = neg_q[el_q] ? -mag34 : mag34;
        mul_b = $signed({2'd0, y_q});
        sh    = 6'd32 - {1'b0, e_q};
      end
      S_CALC: begin
        case (step_q) inside
          [6'd12:6'd14], [6'd21:6'd21]: ax = 2'd0;
          [6'd15:6'd17], [6'd22:6'd22]: ax = 2'd1;
          [6'd18:6'd20], [6'd23:6'd23]: ax = 2'd2;
          default:                      ax = 2'd0;
        endcase
        case (step_q) inside
          [6'd0:6'd11], [6'd24:6'd35]: cls = C_LIN;
          6'd12, 6'd15, 6'd18:         cls = C_FB0;
          6'd13, 6'd16, 6'd19:         cls = C_FB1;
          6'd14, 6'd17, 6'd20:         cls = C_FB2;
          [6'd21:6'd23]:               cls = C_H;
          default:                     cls = C_NONE;
        endcase
        // linear combination table: gravity estimate, error, updated quaternion
        case (step_q)
          6'd0:  begin mul_a = 34'(att_q[1]); mul_b = 34'(att_q[3]); lin_first = 1'b1; end
          6'd1:  begin mul_a = 34'(att_q[0]); mul_b = 34'(att_q[2]); lin_neg = 1'b1; end
          6'd2:  begin mul_a = 34'(att_q[0]); mul_b = 34'(att_q[1]); lin_first = 1'b1; end
          6'd3:  begin mul_a = 34'(att_q[2]); mul_b = 34'(att_q[3]); end
          6'd4:  begin
            mul_a = 34'(att_q[0]); mul_b = 34'(att_q[0]);
            lin_first = 1'b1; lin_base = -HalfQ30;
          end
          6'd5:  begin mul_a = 34'(att_q[3]); mul_b = 34'(att_q[3]); end
          6'd6:  begin mul_a = 34'(an_q[1]); mul_b = 34'(hv_q[2]); lin_first = 1'b1; end
          6'd7:  begin mul_a = 34'(an_q[2]); mul_b = 34'(hv_q[1]); lin_neg = 1'b1; end
          6'd8:  begin mul_a = 34'(an_q[2]); mul_b = 34'(hv_q[0]); lin_first = 1'b1; end
          6'd9:  begin mul_a = 34'(an_q[0]); mul_b = 34'(hv_q[2]); lin_neg = 1'b1; end
          6'd10: begin mul_a = 34'(an_q[0]); mul_b = 34'(hv_q[1]); lin_first = 1'b1; end
          6'd11: begin mul_a = 34'(an_q[1]); mul_b = 34'(hv_q[0]); lin_neg = 1'b1; end
          6'd24: begin
            mul_a = 34'(att_q[1]); mul_b = 34'(h_q[0]);
            lin_first = 1'b1; lin_base = 40'(att_q[0]); lin_neg = 1'b1;
          end
          6'd25: begin mul_a = 34'(att_q[2]); mul_b = 34'(h_q[1]); lin_neg = 1'b1; end
          6'd26: begin mul_a = 34'(att_q[3]); mul_b = 34'(h_q[2]); lin_neg = 1'b1; end
          6'd27: begin
            mul_a = 34'(att_q[0]); mul_b = 34'(h_q[0]);
            lin_first = 1'b1; lin_base = 40'(att_q[1]);
          end
          6'd28: begin mul_a = 34'(att_q[2]); mul_b = 34'(h_q[2]); end
          6'd29: begin mul_a = 34'(att_q[3]); mul_b = 34'(h_q[1]); lin_neg = 1'b1; end
          6'd30: begin
            mul_a = 34'(att_q[0]); mul_b = 34'(h_q[1]);
            lin_first = 1'b1; lin_base = 40'(att_q[2]);
          end
          6'd31: begin mul_a = 34'(att_q[1]); mul_b = 34'(h_q[2]); lin_neg = 1'b1; end
          6'd32: begin mul_a = 34'(att_q[3]); mul_b = 34'(h_q[0]); end
          6'd33: begin
            mul_a = 34'(att_q[0]); mul_b = 34'(h_q[2]);
            lin_first = 1'b1; lin_base = 40'(att_q[3]);
          end
          6'd34: begin mul_a = 34'(att_q[1]); mul_b = 34'(h_q[1]); end
          6'd35: begin mul_a = 34'(att_q[2]); mul_b = 34'(h_q[0]); lin_neg = 1'b1; end
          default: ;
        endcase
        case (cls)
          C_FB0: begin
            mul_a = $signed({2'd0, two_ki_q});
            mul_b = 34'(he_q[ax]);
            sh    = 6'd34;
          end
          C_FB1: begin
            mul_a = 34'(acc_q);
            mul_b = $signed({2'd0, period_q});
            sh    = 6'd32;
          end
          C_FB2: begin
            mul_a = $signed({2'd0, two_kp_q});
            mul_b = 34'(he_q[ax]);
            sh    = 6'd34;
          end
          C_H: begin
            mul_a = g_q[ax];
            mul_b = $signed({2'd0, period_q});
            sh    = 6'd23;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // post-multiply arithmetic
  logic signed [67:0]  term;
  logic signed [39:0]  term40, tv, lin_sum;
  logic signed [31:0]  isum, gsum;

  assign term    = rsh_rnd(prod_q, sh);
  assign term40  = 40'(term);
  assign tv      = lin_neg ? -term40 : term40;
  assign lin_sum = (lin_first ? lin_base : acc_q) + tv;
  assign isum    = sat32(68'(integ_q[ax]) + term);
  assign gsum    = sat32(68'(g_q[ax]) + term);

  // magnitude and pre-shift for normalisation
  logic [35:0] absv [4];
  logic [35:0] orv;
  logic [2:0]  pre_sh;

  always_comb begin
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      absv[i] = nv_q[i][35] ? 36'(-nv_q[i]) : 36'(nv_q[i]);
      orv     = orv | absv[i];
    end
    // bit length of the largest magnitude equals that of the OR of all
    if (orv[35]) begin
      pre_sh = 3'd5;
    end else if (orv[34]) begin
      pre_sh = 3'd4;
    end else if (orv[33]) begin
      pre_sh = 3'd3;
    end else if (orv[32]) begin
      pre_sh = 3'd2;
    end else if (orv[31]) begin
      pre_sh = 3'd1;
    end else begin
      pre_sh = 3'd0;
    end
  end

  logic accel_zero, out_free;
  assign accel_zero = (accel_x_i == 32'sd0) && (accel_y_i == 32'sd0) && (accel_z_i == 32'sd0);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 1'b0;
      step_q      <= '0;
      el_q        <= '0;
      sub_q       <= '0;
      it_q        <= '0;
      norm_qn_q   <= 1'b0;
      nz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      att_q[0]    <= QuatOne;
      att_q[1]    <= '0;
      att_q[2]    <= '0;
      att_q[3]    <= '0;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      integ_q[2]  <= '0;
      for (int i = 0; i < 3; i++) begin
        g_q[i]  <= '0;
        an_q[i] <= '0;
        hv_q[i] <= '0;
        he_q[i] <= '0;
        h_q[i]  <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        nout_q[i] <= '0;
        nv_q[i]   <= '0;
        mag_q[i]  <= '0;
      end
      neg_q <= '0;
      s_q   <= '0;
      m_q   <= '0;
      e_q   <= '0;
      y_q   <= '0;
      y2_q  <= '0;
      t_q   <= '0;
      m31_q <= '0;
      acc_q <= '0;
    end else begin
      // on completion the done state raises the beat itself
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            g_q[0]  <= 34'(rate_x_i);
            g_q[1]  <= 34'(rate_y_i);
            g_q[2]  <= 34'(rate_z_i);
            phase_q <= 1'b0;
            if (accel_zero) begin
              step_q  <= StepH;
              state_q <= S_CALC;
            end else begin
              nv_q[0]   <= 36'(accel_x_i);
              nv_q[1]   <= 36'(accel_y_i);
              nv_q[2]   <= 36'(accel_z_i);
              nv_q[3]   <= '0;
              norm_qn_q <= 1'b0;
              state_q   <= S_NMAG;
            end
          end
        end
        S_NMAG: begin
          for (int i = 0; i < 4; i++) begin
            mag_q[i] <= 31'(absv[i] >> pre_sh);
            neg_q[i] <= nv_q[i][35];
          end
          s_q     <= '0;
          el_q    <= '0;
          phase_q <= 1'b0;
          state_q <= S_NSQ;
        end
        S_NSQ: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            s_q <= s_q + prod_q[63:0];
            if (el_q == 2'd3) begin
              state_q <= S_NCHK;
            end else begin
              el_q <= el_q + 2'd1;
            end
          end
        end
        S_NCHK: begin
          if (s_q == '0) begin
            nz_q    <= 1'b0;
            state_q <= S_NEND;
          end else begin
            m_q     <= s_q;
            e_q     <= '0;
            state_q <= S_NSHF;
          end
        end
        S_NSHF: begin
          // one byte or one bit pair a cycle until the top pair is nonzero
          if (m_q[63:56] == 8'd0) begin
            m_q <= m_q << 8;
            e_q <= e_q + 5'd4;
          end else if (m_q[63:62] == 2'd0) begin
            m_q <= m_q << 2;
            e_q <= e_q + 5'd1;
          end else begin
            state_q <= S_NSEED;
          end
        end
        S_NSEED: begin
          y_q     <= {1'b0, seed_lut(m_q[63:60] - 4'd4), 16'd0};
          m31_q   <= m_q[63:33];
          it_q    <= '0;
          sub_q   <= '0;
          phase_q <= 1'b0;
          state_q <= S_NNEWT;
        end
        S_NNEWT: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            case (sub_q)
              2'd0: begin
                y2_q  <= prod_q[62:30];
                sub_q <= 2'd1;
              end
              2'd1: begin
                t_q   <= prod_q[63:31];
                sub_q <= 2'd2;
              end
              default: begin
                y_q   <= prod_q[62:31];
                sub_q <= 2'd0;
                if (it_q == ItLast) begin
                  el_q    <= '0;
                  state_q <= S_NOUT;
                end else begin
                  it_q <= it_q + ItW'(1);
                end
              end
            endcase
          end
        end
        S_NOUT: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            nout_q[el_q] <= sat32(term);
            if (el_q == 2'd3) begin
              nz_q    <= 1'b1;
              state_q <= S_NEND;
            end else begin
              el_q <= el_q + 2'd1;
            end
          end
        end
        S_NEND: begin
          if (norm_qn_q) begin
            state_q <= S_DONE;
          end else begin
            an_q[0] <= nout_q[0];
            an_q[1] <= nout_q[1];
            an_q[2] <= nout_q[2];
            step_q  <= '0;
            phase_q <= 1'b0;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            case (cls)
              C_LIN: acc_q <= lin_sum;
              C_FB0: acc_q <= term40;
              C_FB1: begin
                if (two_ki_q != '0) begin
                  integ_q[ax] <= isum;
                  g_q[ax]     <= g_q[ax] + 34'(isum);
                end else begin
                  integ_q[ax] <= '0;
                end
              end
              C_FB2: g_q[ax] <= 34'(gsum);
              C_H:   h_q[ax] <= sat32(term);
              default: ;
            endcase
            case (step_q)
              6'd1:  hv_q[0] <= sat32(68'(lin_sum));
              6'd3:  hv_q[1] <= sat32(68'(lin_sum));
              6'd5:  hv_q[2] <= sat32(68'(lin_sum));
              6'd7:  he_q[0] <= sat32(68'(lin_sum));
              6'd9:  he_q[1] <= sat32(68'(lin_sum));
              6'd11: he_q[2] <= sat32(68'(lin_sum));
              6'd26: nv_q[0] <= 36'(lin_sum);
              6'd29: nv_q[1] <= 36'(lin_sum);
              6'd32: nv_q[2] <= 36'(lin_sum);
              6'd35: nv_q[3] <= 36'(lin_sum);
              default: ;
            endcase
            if (step_q == StepLast) begin
              norm_qn_q <= 1'b1;
              state_q   <= S_NMAG;
            end else begin
              step_q <= step_q + 6'd1;
            end
          end
        end
        S_DONE: begin
          // attitude doubles as the output payload: update only once the slot is free
          if (out_free) begin
            if (nz_q) begin
              att_q[0] <= nout_q[0];
              att_q[1] <= nout_q[1];
              att_q[2] <= nout_q[2];
              att_q[3] <= nout_q[3];
            end else begin
              att_q[0] <= QuatOne;
              att_q[1] <= '0;
              att_q[2] <= '0;
              att_q[3] <= '0;
            end
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign quat_w_o    = att_q[0];
  assign quat_x_o    = att_q[1];
  assign quat_y_o    = att_q[2];
  assign quat_z_o    = att_q[3];

  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NSEED |-> m_q[63:62] != 2'b00)
    else $error("normaliser left mantissa below range");

  a_accel_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NCHK && !norm_qn_q |-> s_q != '0)
    else $error("nonzero accelerometer gave zero square sum");

  a_att_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_DONE |=> $stable(att_q[0]) && $stable(att_q[1]) &&
                          $stable(att_q[2]) && $stable(att_q[3]))
    else $error("attitude changed outside the update step");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("result beat not raised on completion");

endmodule

### tb/imu_aqu_checker.sv
module imu_aqu_checker
  import imu_aqu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_stall_i,
  input  logic [31:0]  rate_x_i,
  input  logic [31:0]  rate_y_i,
  input  logic [31:0]  rate_z_i,
  input  logic [31:0]  accel_x_i,
  input  logic [31:0]  accel_y_i,
  input  logic [31:0]  accel_z_i,
  input  logic         out_valid_i,
  input  logic         out_stall_i,
  input  logic [31:0]  quat_w_i,
  input  logic [31:0]  quat_x_i,
  input  logic [31:0]  quat_y_i,
  input  logic [31:0]  quat_z_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_cnt_o,
  output int           pending_o
);

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } quat_t;

  localparam int unsigned SeedTab [12] = '{30894, 27945, 25705, 23930, 22479, 21263,
                                           20225, 19325, 18536, 17837, 17211, 16646};
  localparam int RsqrtSteps = 4;

  quat_t       quat_q[$];
  longint      att [4];
  longint      integ [3];
  logic [31:0] kp, ki, period;

  // arithmetic shift right, round half up
  function automatic longint shr_rnd(input longint v, input int s);
    longint f;
    f = v >>> s;
    return f + ((v >> (s - 1)) & 64'd1);
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return shr_rnd(a * b, 30);
  endfunction

  function automatic longint unsigned inv_sqrt(input longint unsigned s, output int k);
    longint unsigned m, y, y2, t, m31;
    int e;
    m = s;
    e = 0;
    while (m < (64'd1 << 62)) begin
      m = m << 2;
      e++;
    end
    y = 64'(SeedTab[((m >> 60) - 64'd4) & 64'd15]) << 16;
    m31 = m >> 33;
    for (int i = 0; i < RsqrtSteps; i++) begin
      y2 = (y * y) >> 30;
      t = (m31 * y2) >> 31;
      y = (y * ((64'd3 << 30) - t)) >> 31;
    end
    k = e;
    return y;
  endfunction

  // scale to unit length in Q2.30; 0 when every component is zero
  function automatic bit unit_vec(input longint v [4], input int n, output longint o [4]);
    longint unsigned mag [4];
    longint unsigned mx, s, r;
    longint sq;
    int p, k;
    mx = 0;
    s = 0;
    p = 0;
    o = '{0, 0, 0, 0};
    for (int i = 0; i < n; i++) begin
      mag[i] = (v[i] < 0) ? 64'd0 - longint'(v[i]) : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> p) > 64'h7fff_ffff) p++;
    for (int i = 0; i < n; i++) begin
      mag[i] = mag[i] >> p;
      s += mag[i] * mag[i];
    end
    if (s == 0) return 1'b0;
    r = inv_sqrt(s, k);
    for (int i = 0; i < n; i++) begin
      sq = (v[i] < 0) ? -longint'(mag[i]) : longint'(mag[i]);
      o[i] = clip32(shr_rnd(sq * longint'(r), 32 - k));
    end
    return 1'b1;
  endfunction

  task automatic advance_attitude(input longint rate [3], input longint acc [4]);
    longint g [3];
    longint hv [3];
    longint he [3];
    longint h [3];
    longint an [4];
    longint qn [4];
    longint qo [4];
    longint ge, inc;
    quat_t r;
    g = rate;
    if (acc[0] != 0 || acc[1] != 0 || acc[2] != 0) begin
      void'(unit_vec(acc, 3, an));
      hv[0] = clip32(mul_q30(att[1], att[3]) - mul_q30(att[0], att[2]));
      hv[1] = clip32(mul_q30(att[0], att[1]) + mul_q30(att[2], att[3]));
      hv[2] = clip32(mul_q30(att[0], att[0]) - (64'sd1 << 29) + mul_q30(att[3], att[3]));
      he[0] = clip32(mul_q30(an[1], hv[2]) - mul_q30(an[2], hv[1]));
      he[1] = clip32(mul_q30(an[2], hv[0]) - mul_q30(an[0], hv[2]));
      he[2] = clip32(mul_q30(an[0], hv[1]) - mul_q30(an[1], hv[0]));
      for (int i = 0; i < 3; i++) begin
        if (ki != 0) begin
          ge = shr_rnd(longint'({32'd0, ki}) * he[i], 34);
          inc = shr_rnd(ge * longint'({32'd0, period}), 32);
          integ[i] = clip32(integ[i] + inc);
          g[i] += integ[i];
        end else begin
          integ[i] = 0;
        end
        g[i] = clip32(g[i] + shr_rnd(longint'({32'd0, kp}) * he[i], 34));
      end
    end
    for (int i = 0; i < 3; i++) h[i] = clip32(shr_rnd(g[i] * longint'({32'd0, period}), 23));
    qn[0] = att[0] - mul_q30(att[1], h[0]) - mul_q30(att[2], h[1]) - mul_q30(att[3], h[2]);
    qn[1] = att[1] + mul_q30(att[0], h[0]) + mul_q30(att[2], h[2]) - mul_q30(att[3], h[1]);
    qn[2] = att[2] + mul_q30(att[0], h[1]) - mul_q30(att[1], h[2]) + mul_q30(att[3], h[0]);
    qn[3] = att[3] + mul_q30(att[0], h[2]) + mul_q30(att[1], h[1]) - mul_q30(att[2], h[0]);
    if (unit_vec(qn, 4, qo)) begin
      att = qo;
    end else begin
      att = '{64'sd1 << 30, 0, 0, 0};
    end
    r.w = att[0][31:0];
    r.x = att[1][31:0];
    r.y = att[2][31:0];
    r.z = att[3][31:0];
    quat_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t e;
    if (!rst_ni) begin
      att = '{64'sd1 << 30, 0, 0, 0};
      integ = '{0, 0, 0};
      kp = TwoKpReset;
      ki = TwoKiReset;
      period = PeriodReset;
      quat_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegTwoKp:        kp = pwdata;
          RegTwoKi:        ki = pwdata;
          RegSamplePeriod: period = pwdata;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        advance_attitude('{longint'($signed(rate_x_i)), longint'($signed(rate_y_i)),
                           longint'($signed(rate_z_i))},
                         '{longint'($signed(accel_x_i)), longint'($signed(accel_y_i)),
                           longint'($signed(accel_z_i)), 0});
      end
      if (out_valid_i && !out_stall_i) begin
        if (quat_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h %h %h %h", $time,
                   quat_w_i, quat_x_i, quat_y_i, quat_z_i);
          fail_cnt_o++;
        end else begin
          e = quat_q.pop_front();
          check_field("quat_w", e.w, quat_w_i);
          check_field("quat_x", e.x, quat_x_i);
          check_field("quat_y", e.y, quat_y_i);
          check_field("quat_z", e.z, quat_z_i);
        end
      end
      pending_o = quat_q.size();
    end
  end

endmodule

### tb/tb_top.sv
module tb_top
  import imu_aqu_pkg::*;
();

  localparam int IdleLimit = 20000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [31:0] rate_x_i, rate_y_i, rate_z_i, accel_x_i, accel_y_i, accel_z_i;
  logic [31:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_cnt, pending;
  int          sent, got, idle_cnt;
  int          snd_pct, rcv_pct;

  imu_attitude_quaternion_update u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .rate_x_i, .rate_y_i, .rate_z_i, .accel_x_i, .accel_y_i, .accel_z_i,
    .out_valid_o, .out_stall_i, .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  imu_aqu_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .rate_x_i, .rate_y_i, .rate_z_i, .accel_x_i, .accel_y_i, .accel_z_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .quat_w_i(quat_w_o), .quat_x_i(quat_x_o), .quat_y_i(quat_y_o), .quat_z_i(quat_z_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      got <= 0;
      idle_cnt <= 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_pct);
      if (out_valid_o && !out_stall_i) got <= got + 1;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (idle_cnt >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki,
                           input logic [31:0] per);
    reg_write({RegTwoKp, 2'b00}, kp);
    reg_write({RegTwoKi, 2'b00}, ki);
    reg_write({RegSamplePeriod, 2'b00}, per);
  endtask

  // one sample beat; valid stays up straight into the next beat unless a gap is drawn
  task automatic send_sample(input logic [31:0] gx, gy, gz, ax, ay, az);
    while ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rate_x_i <= gx;
    rate_y_i <= gy;
    rate_z_i <= gz;
    accel_x_i <= ax;
    accel_y_i <= ay;
    accel_z_i <= az;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (got != sent) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(input int centre, input int spread);
    return 32'(centre + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hffff_ffff;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_sample;
    int kind;
    kind = $urandom_range(9);
    if (kind <= 5) begin
      // plausible motion: gravity on one axis, modest rates
      send_sample(near(0, 4 << 20), near(0, 4 << 20), near(0, 4 << 20),
                  near(0, 1 << 19), near(0, 1 << 19), near(1 << 20, 1 << 19));
    end else if (kind == 6) begin
      send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind == 7) begin
      send_sample($urandom, $urandom, $urandom, 32'h0, 32'h0, 32'h0);
    end else if (kind == 8) begin
      send_sample(edge_word(), edge_word(), edge_word(), edge_word(), edge_word(),
                  edge_word());
    end else begin
      send_sample(near(0, 1 << 29), near(0, 1 << 29), near(0, 1 << 29),
                  $urandom >> $urandom_range(31), $urandom, near(0, 8));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rate_x_i = '0;
    rate_y_i = '0;
    rate_z_i = '0;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    snd_pct = 0;
    rcv_pct = 0;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gains first
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(32'h0010_0000, 32'hfff0_0000, 32'h0008_0000, 32'h0, 32'h0, 32'h0);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0010_0000);
    send_sample(32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff);
    send_sample(32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
    drain;
    // register index beyond the three is ignored
    reg_write(4'd12, 32'hdead_beef);
    // extreme gains and period: rate overflow and saturated half-angle steps
    set_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0010_0000, 32'h0, 32'h0);
    send_sample(32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0);
    send_sample(32'h4000_0000, 32'hc000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    drain;
    // zero period: renormalise only
    set_gains(32'h0, 32'h0100_0000, 32'h0);
    send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h0, 32'h0, 32'h0010_0000);
    send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    drain;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_gains(TwoKpReset, TwoKiReset, PeriodReset);
        1: set_gains(32'h0200_0000, 32'h0040_0000, 32'd4294967);
        2: set_gains(32'h0, 32'h0, 32'h1);
        3: set_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        4: set_gains($urandom, $urandom >> 4, $urandom >> 8);
        default: set_gains($urandom, $urandom, $urandom);
      endcase
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 81; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 81; end
        default: begin snd_pct = 9; rcv_pct = 9; end
      endcase
      repeat (140) random_sample();
      drain;
    end

    repeat (250) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
